// File: hdl/pe_export_address_resolver_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PE export address resolver
// Shared concurrent check forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PE_EXPORT_ADDRESS_RESOLVER_DEFINES_SVH
`define PE_EXPORT_ADDRESS_RESOLVER_DEFINES_SVH

// same-cycle implication
`define PEAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pear: same-cycle check failed");

// next-cycle implication
`define PEAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pear: next-cycle check failed");

`endif

// File: hdl/pear_pkg.sv
// ----------------------------------------------------------------------------
// pear_pkg
// Types, constants and command codes shared by the export resolver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pear_pkg;

    localparam int IMAGE_BYTES  = 65536;
    localparam int MAX_NAMES    = 4096;
    localparam int MAX_SECTIONS = 96;

    localparam int ADDR_W = $clog2(IMAGE_BYTES);
    localparam int NSEC_W = $clog2(MAX_SECTIONS + 1);
    localparam int CNT_W  = $clog2(MAX_NAMES + 1);

    localparam int IN_W  = 80;
    localparam int OUT_W = 40;

    // image layout offsets
    localparam int OFF_LFANEW    = 60;
    localparam int OFF_NSEC      = 6;
    localparam int OFF_OPT_SIZE  = 20;
    localparam int OFF_SEC_TAB   = 24;
    localparam int OFF_SEC_ALIGN = 56;
    localparam int OFF_FILE_ALGN = 60;
    localparam int OFF_HDR_SIZE  = 84;
    localparam int OFF_EXPORT    = 120;
    localparam int OFF_SEC_VA    = 12;
    localparam int OFF_SEC_RAW   = 20;
    localparam int SEC_ENTRY     = 40;
    localparam int OFF_ORD_BASE  = 16;
    localparam int OFF_NUM_NAMES = 24;
    localparam int OFF_FUNCS     = 28;
    localparam int OFF_NAMES     = 32;
    localparam int OFF_ORDS      = 36;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_NAME  = 2'd1,
        OP_ORD   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        A_60, A_H120, A_H56, A_H60, A_H84, A_H6, A_H20,
        A_S12, A_S52, A_S20,
        A_D16, A_D24, A_D28, A_D32, A_D36,
        A_FIDX, A_NAME, A_ORD
    } addr_sel_t;

    typedef enum logic [4:0] {
        LD_NONE, LD_H, LD_RVA, LD_TMP, LD_NSEC, LD_TAB, LD_VA, LD_NEXT_SEC,
        LD_CV_RVA, LD_CV_SEC, LD_DIR, LD_FUNCS, LD_NAMES, LD_ORDS, LD_COUNT,
        LD_BASE, LD_ORD, LD_NEXT_NAME, LD_RES_HIT, LD_RES_MISS
    } ld_t;

    typedef enum logic [1:0] {
        RET_DIR, RET_FUNCS, RET_NAMES, RET_ORDS
    } ret_t;

    typedef enum logic [4:0] {
        S_IDLE, S_H, S_EXP, C_SA, C_FA, C_HS, C_NS, C_OP, C_VA, C_VN, C_RAW,
        S_RET, S_COUNT, S_FRVA, S_NRVA, S_ORVA, S_BASE, S_NCHK, S_NAME,
        S_ORD, S_FUNC, S_OUT
    } state_t;

    typedef struct packed {
        logic      latch;
        logic      rd_go;
        logic      rd_half;
        addr_sel_t addr_sel;
        ld_t       ld;
    } dp_cmd_t;

    typedef struct packed {
        logic rd_done;
        logic word_eq_tmp;
        logic rva_le_word;
        logic w16_zero;
        logic last_sec;
        logic in_range;
        logic key_eq;
        logic names_end;
    } dp_status_t;

endpackage

// File: hdl/pear_image_mem.sv
// ----------------------------------------------------------------------------
// pear_image_mem
// Byte-wide image store, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pear_image_mem (
    input  logic                       clk,
    input  logic                       we,
    input  logic [pear_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                 wdata,
    input  logic [pear_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                 rdata
);
    import pear_pkg::*;

    logic [7:0] mem [IMAGE_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/pear_datapath.sv
// ----------------------------------------------------------------------------
// pear_datapath
// Byte read sequencer, address generation and the lookup working registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pear_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pear_pkg::dp_cmd_t           cmd,
    output pear_pkg::dp_status_t        st,
    input  logic [31:0]                 name_rva,
    input  logic [15:0]                 ordinal_in,
    output logic [pear_pkg::ADDR_W-1:0] mem_raddr,
    input  logic [7:0]                  mem_rdata,
    output logic [31:0]                 function_rva,
    output logic                        found
);
    import pear_pkg::*;

    logic        rd_busy_reg, rd_busy_next;
    logic [2:0]  rd_iss_reg, rd_iss_next;
    logic [1:0]  rd_last_reg, rd_last_next;
    logic        cap_vld_reg, cap_vld_next;
    logic [1:0]  cap_lane_reg;
    logic        cap_oob_reg;
    logic [31:0] rd_base_reg;
    logic [31:0] word_reg;

    logic [31:0] h_reg, rva_reg, tmp_reg, cv_reg, sec_reg, va_reg;
    logic [31:0] dir_reg, funcs_reg, name_ptr_reg, ord_ptr_reg, idx_reg;
    logic [31:0] key_reg, res_reg;
    logic [15:0] ordv_reg;
    logic [NSEC_W-1:0] nsec_reg, sidx_reg;
    logic [CNT_W-1:0]  count_reg, ni_reg;
    logic        found_reg;

    logic        start, issuing;
    logic [32:0] iss_sum;
    logic [31:0] addr;
    logic [31:0] rd_word;
    logic [7:0]  cap_byte;

    assign start   = cmd.rd_go && !rd_busy_reg;
    assign issuing = rd_busy_reg && (rd_iss_reg <= {1'b0, rd_last_reg});
    assign iss_sum = {1'b0, rd_base_reg} + 33'(rd_iss_reg);
    assign mem_raddr = iss_sum[ADDR_W-1:0];
    assign cap_byte = cap_oob_reg ? 8'd0 : mem_rdata;

    always_comb
    begin
        unique case (cmd.addr_sel)
            A_60:    addr = 32'(OFF_LFANEW);
            A_H120:  addr = h_reg + 32'(OFF_EXPORT);
            A_H56:   addr = h_reg + 32'(OFF_SEC_ALIGN);
            A_H60:   addr = h_reg + 32'(OFF_FILE_ALGN);
            A_H84:   addr = h_reg + 32'(OFF_HDR_SIZE);
            A_H6:    addr = h_reg + 32'(OFF_NSEC);
            A_H20:   addr = h_reg + 32'(OFF_OPT_SIZE);
            A_S12:   addr = sec_reg + 32'(OFF_SEC_VA);
            A_S52:   addr = sec_reg + 32'(OFF_SEC_VA + SEC_ENTRY);
            A_S20:   addr = sec_reg + 32'(OFF_SEC_RAW);
            A_D16:   addr = dir_reg + 32'(OFF_ORD_BASE);
            A_D24:   addr = dir_reg + 32'(OFF_NUM_NAMES);
            A_D28:   addr = dir_reg + 32'(OFF_FUNCS);
            A_D32:   addr = dir_reg + 32'(OFF_NAMES);
            A_D36:   addr = dir_reg + 32'(OFF_ORDS);
            A_FIDX:  addr = funcs_reg + {idx_reg[29:0], 2'b00};
            A_NAME:  addr = name_ptr_reg;
            A_ORD:   addr = ord_ptr_reg;
            default: addr = 32'd0;
        endcase
    end

    // merge the byte in flight into the assembled word
    always_comb
    begin
        rd_word = word_reg;
        if (cap_vld_reg)
        begin
            case (cap_lane_reg)
                2'd0:    rd_word[7:0]   = cap_byte;
                2'd1:    rd_word[15:8]  = cap_byte;
                2'd2:    rd_word[23:16] = cap_byte;
                default: rd_word[31:24] = cap_byte;
            endcase
        end
    end

    always_comb
    begin
        st.rd_done     = cap_vld_reg && (cap_lane_reg == rd_last_reg);
        st.word_eq_tmp = (rd_word == tmp_reg);
        st.rva_le_word = (rva_reg <= rd_word);
        st.w16_zero    = (rd_word[15:0] == 16'd0);
        st.last_sec    = ({1'b0, sidx_reg} + 1'b1) >= {1'b0, nsec_reg};
        st.in_range    = (rva_reg >= va_reg) && (rva_reg < rd_word);
        st.key_eq      = (rd_word == key_reg);
        st.names_end   = (ni_reg >= count_reg);
    end

    always_comb
    begin
        rd_busy_next = rd_busy_reg;
        rd_iss_next  = rd_iss_reg;
        rd_last_next = rd_last_reg;
        cap_vld_next = issuing;
        if (start)
        begin
            rd_busy_next = 1'b1;
            rd_iss_next  = 3'd0;
            rd_last_next = cmd.rd_half ? 2'd1 : 2'd3;
        end
        else
        begin
            if (issuing)
            begin
                rd_iss_next = rd_iss_reg + 3'd1;
            end
            if (st.rd_done)
            begin
                rd_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_busy_reg <= 1'b0;
            rd_iss_reg  <= 3'd0;
            rd_last_reg <= 2'd3;
            cap_vld_reg <= 1'b0;
        end
        else
        begin
            rd_busy_reg <= rd_busy_next;
            rd_iss_reg  <= rd_iss_next;
            rd_last_reg <= rd_last_next;
            cap_vld_reg <= cap_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_lane_reg <= rd_iss_reg[1:0];
        cap_oob_reg  <= (iss_sum >= 33'(IMAGE_BYTES));
        if (start)
        begin
            rd_base_reg <= addr;
            word_reg    <= 32'd0;
        end
        else if (cap_vld_reg)
        begin
            word_reg <= rd_word;
        end

        if (cmd.latch)
        begin
            key_reg  <= name_rva;
            ordv_reg <= ordinal_in;
        end

        unique case (cmd.ld)
            LD_NONE: ;
            LD_H:    h_reg   <= rd_word;
            LD_RVA:  rva_reg <= rd_word;
            LD_TMP:  tmp_reg <= rd_word;
            LD_NSEC:
            begin
                if (rd_word[15:0] > 16'(MAX_SECTIONS))
                    nsec_reg <= NSEC_W'(MAX_SECTIONS);
                else
                    nsec_reg <= rd_word[NSEC_W-1:0];
            end
            LD_TAB:
            begin
                sec_reg  <= h_reg + 32'(OFF_SEC_TAB) + {16'd0, rd_word[15:0]};
                sidx_reg <= '0;
            end
            LD_VA:   va_reg <= rd_word;
            LD_NEXT_SEC:
            begin
                sec_reg  <= sec_reg + 32'(SEC_ENTRY);
                sidx_reg <= sidx_reg + 1'b1;
            end
            LD_CV_RVA: cv_reg <= rva_reg;
            LD_CV_SEC: cv_reg <= rva_reg - va_reg + rd_word;
            LD_DIR:    dir_reg <= cv_reg;
            LD_FUNCS:  funcs_reg <= cv_reg;
            LD_NAMES:
            begin
                name_ptr_reg <= cv_reg;
                ni_reg       <= '0;
            end
            LD_ORDS:   ord_ptr_reg <= cv_reg;
            LD_COUNT:
            begin
                if (rd_word > 32'(MAX_NAMES))
                    count_reg <= CNT_W'(MAX_NAMES);
                else
                    count_reg <= rd_word[CNT_W-1:0];
            end
            LD_BASE:   idx_reg <= {16'd0, ordv_reg} - rd_word;
            LD_ORD:    idx_reg <= {16'd0, rd_word[15:0]};
            LD_NEXT_NAME:
            begin
                name_ptr_reg <= name_ptr_reg + 32'd4;
                ord_ptr_reg  <= ord_ptr_reg + 32'd2;
                ni_reg       <= ni_reg + 1'b1;
            end
            LD_RES_HIT:
            begin
                res_reg   <= rd_word;
                found_reg <= 1'b1;
            end
            LD_RES_MISS:
            begin
                res_reg   <= 32'd0;
                found_reg <= 1'b0;
            end
            default: ;
        endcase
    end

    assign function_rva = res_reg;
    assign found        = found_reg;

endmodule

// File: hdl/pear_ctrl.sv
// ----------------------------------------------------------------------------
// pear_ctrl
// Lookup sequencer: header reads, RVA conversion walk and export table walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pe_export_address_resolver_defines.svh"

module pear_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  pear_pkg::op_t        in_op,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pear_pkg::dp_cmd_t    cmd,
    input  pear_pkg::dp_status_t st
);
    import pear_pkg::*;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;
    logic   name_reg, name_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_DIR;
            name_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            name_reg  <= name_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        name_next    = name_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.latch    = 1'b0;
        cmd.rd_go    = 1'b0;
        cmd.rd_half  = 1'b0;
        cmd.addr_sel = A_60;
        cmd.ld       = LD_NONE;

        unique case (state_reg) inside
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && ((in_op == OP_NAME) || (in_op == OP_ORD)))
                begin
                    cmd.latch  = 1'b1;
                    name_next  = (in_op == OP_NAME);
                    state_next = S_H;
                end
            end
            S_H:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_60;
                if (st.rd_done)
                begin
                    cmd.ld = LD_H;
                    state_next = S_EXP;
                end
            end
            S_EXP, S_FRVA, S_NRVA, S_ORVA:
            begin
                cmd.rd_go = 1'b1;
                unique case (state_reg)
                    S_EXP:   cmd.addr_sel = A_H120;
                    S_FRVA:  cmd.addr_sel = A_D28;
                    S_NRVA:  cmd.addr_sel = A_D32;
                    default: cmd.addr_sel = A_D36;
                endcase
                if (st.rd_done)
                begin
                    cmd.ld = LD_RVA;
                    state_next = C_SA;
                    unique case (state_reg)
                        S_EXP:   ret_next = RET_DIR;
                        S_FRVA:  ret_next = RET_FUNCS;
                        S_NRVA:  ret_next = RET_NAMES;
                        default: ret_next = RET_ORDS;
                    endcase
                end
            end
            C_SA:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_H56;
                if (st.rd_done)
                begin
                    cmd.ld = LD_TMP;
                    state_next = C_FA;
                end
            end
            C_FA:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_H60;
                if (st.rd_done)
                begin
                    if (st.word_eq_tmp)
                    begin
                        cmd.ld = LD_CV_RVA;
                        state_next = S_RET;
                    end
                    else
                    begin
                        state_next = C_HS;
                    end
                end
            end
            C_HS:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_H84;
                if (st.rd_done)
                begin
                    if (st.rva_le_word)
                    begin
                        cmd.ld = LD_CV_RVA;
                        state_next = S_RET;
                    end
                    else
                    begin
                        state_next = C_NS;
                    end
                end
            end
            C_NS:
            begin
                cmd.rd_go = 1'b1;
                cmd.rd_half = 1'b1;
                cmd.addr_sel = A_H6;
                if (st.rd_done)
                begin
                    if (st.w16_zero)
                    begin
                        cmd.ld = LD_CV_RVA;
                        state_next = S_RET;
                    end
                    else
                    begin
                        cmd.ld = LD_NSEC;
                        state_next = C_OP;
                    end
                end
            end
            C_OP:
            begin
                cmd.rd_go = 1'b1;
                cmd.rd_half = 1'b1;
                cmd.addr_sel = A_H20;
                if (st.rd_done)
                begin
                    cmd.ld = LD_TAB;
                    state_next = C_VA;
                end
            end
            C_VA:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_S12;
                if (st.rd_done)
                begin
                    cmd.ld = LD_VA;
                    state_next = st.last_sec ? C_RAW : C_VN;
                end
            end
            C_VN:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_S52;
                if (st.rd_done)
                begin
                    if (st.in_range)
                    begin
                        state_next = C_RAW;
                    end
                    else
                    begin
                        cmd.ld = LD_NEXT_SEC;
                        state_next = C_VA;
                    end
                end
            end
            C_RAW:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_S20;
                if (st.rd_done)
                begin
                    cmd.ld = LD_CV_SEC;
                    state_next = S_RET;
                end
            end
            S_RET:
            begin
                unique case (ret_reg)
                    RET_DIR:
                    begin
                        cmd.ld = LD_DIR;
                        state_next = S_FRVA;
                    end
                    RET_FUNCS:
                    begin
                        cmd.ld = LD_FUNCS;
                        state_next = name_reg ? S_COUNT : S_BASE;
                    end
                    RET_NAMES:
                    begin
                        cmd.ld = LD_NAMES;
                        state_next = S_ORVA;
                    end
                    default:
                    begin
                        cmd.ld = LD_ORDS;
                        state_next = S_NCHK;
                    end
                endcase
            end
            S_COUNT:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_D24;
                if (st.rd_done)
                begin
                    cmd.ld = LD_COUNT;
                    state_next = S_NRVA;
                end
            end
            S_BASE:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_D16;
                if (st.rd_done)
                begin
                    cmd.ld = LD_BASE;
                    state_next = S_FUNC;
                end
            end
            S_NCHK:
            begin
                if (st.names_end)
                begin
                    cmd.ld = LD_RES_MISS;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_NAME;
                end
            end
            S_NAME:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_NAME;
                if (st.rd_done)
                begin
                    if (st.key_eq)
                    begin
                        state_next = S_ORD;
                    end
                    else
                    begin
                        cmd.ld = LD_NEXT_NAME;
                        state_next = S_NCHK;
                    end
                end
            end
            S_ORD:
            begin
                cmd.rd_go = 1'b1;
                cmd.rd_half = 1'b1;
                cmd.addr_sel = A_ORD;
                if (st.rd_done)
                begin
                    cmd.ld = LD_ORD;
                    state_next = S_FUNC;
                end
            end
            S_FUNC:
            begin
                cmd.rd_go = 1'b1;
                cmd.addr_sel = A_FIDX;
                if (st.rd_done)
                begin
                    cmd.ld = LD_RES_HIT;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `PEAR_ASSERT_IMP(a_out_blocks_in, clk, rst_n, out_valid, !in_ready)
    `PEAR_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
    `PEAR_ASSERT_IMP(a_done_in_read, clk, rst_n, st.rd_done, cmd.rd_go)

endmodule

// File: hdl/pe_export_address_resolver.sv
// Load item: written to the image store in the accepting cycle, no result.
// Lookup: each 32-bit and each 16-bit image read goes byte by byte through
// the single byte read port of the image store; RVA conversion walks the section table
// one section at a time, and a name search compares the names in order.
// One item at a time; the next item is taken once the result has been accepted.
// Reset (rst_n low, asynchronous) idles the sequencer; the image store is not cleared.
// ----------------------------------------------------------------------------
// pe_export_address_resolver
// Resolves exported function RVAs from a PE image held in an internal store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pe_export_address_resolver (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // op[1:0], byte_address[17:2], load_byte[25:18], name_rva[57:26],
    // ordinal_in[73:58], zero fill [79:74]
    input  logic [pear_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // function_rva[31:0], found[32], zero fill [39:33]
    output logic [pear_pkg::OUT_W-1:0] m_axis_tdata
);
    import pear_pkg::*;

    op_t               in_op;
    logic [15:0]       byte_address;
    logic [7:0]        load_byte;
    logic [31:0]       name_rva;
    logic [15:0]       ordinal_in;
    logic              accept;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;
    dp_cmd_t           cmd;
    dp_status_t        st;
    logic [31:0]       function_rva;
    logic              found;

    assign in_op        = op_t'(s_axis_tdata[1:0]);
    assign byte_address = s_axis_tdata[17:2];
    assign load_byte    = s_axis_tdata[25:18];
    assign name_rva     = s_axis_tdata[57:26];
    assign ordinal_in   = s_axis_tdata[73:58];

    assign accept = s_axis_tvalid && s_axis_tready;
    assign mem_we = accept && (in_op == OP_LOAD) && ({1'b0, byte_address} < 17'(IMAGE_BYTES));

    pear_image_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (byte_address[ADDR_W-1:0]),
        .wdata (load_byte),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pear_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (in_op),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .st        (st)
    );

    pear_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .name_rva     (name_rva),
        .ordinal_in   (ordinal_in),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .function_rva (function_rva),
        .found        (found)
    );

    assign m_axis_tdata = {7'd0, found, function_rva};

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// PE export address resolver testbench
// Builds small PE images item by item, runs name and ordinal lookups against
// them and checks every result with an internal image model and resolver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import pear_pkg::*;

    typedef struct {
        logic [31:0] rva;
        logic        hit;
    } export_res_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;

    // image model
    logic [7:0]          img [IMAGE_BYTES];
    bit                  written [IMAGE_BYTES];
    longint              first_gap;

    export_res_t         pending_res[$];
    logic [31:0]         export_names[$];
    logic [31:0]         ord_base;
    logic [31:0]         hdr_off;
    logic [31:0]         dir_off;
    int                  func_count;

    int                  mismatches;
    int                  n_loads;
    int                  n_name_hits;
    int                  n_name_miss;
    int                  n_ord;
    int                  n_results;
    bit                  no_idle;
    int                  stall;

    pe_export_address_resolver u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Image model and resolver
    // ------------------------------------------------------------------------
    function automatic logic [31:0] img_byte(longint unsigned a);
        if (a < IMAGE_BYTES)
        begin
            if (!written[a] && first_gap < 0)
                first_gap = a;
            return {24'd0, img[a]};
        end
        return 32'd0;
    endfunction

    function automatic logic [31:0] img_half(logic [31:0] a);
        longint unsigned b;
        b = a;
        return img_byte(b) | (img_byte(b + 1) << 8);
    endfunction

    function automatic logic [31:0] img_word(logic [31:0] a);
        longint unsigned b;
        b = a;
        return img_byte(b) | (img_byte(b + 1) << 8) | (img_byte(b + 2) << 16)
            | (img_byte(b + 3) << 24);
    endfunction

    function automatic logic [31:0] rva_to_file(logic [31:0] rva);
        logic [31:0] h;
        logic [31:0] nsec;
        logic [31:0] opt;
        logic [31:0] tab;
        logic [31:0] va;
        logic [31:0] va_next;
        logic [31:0] raw;
        logic [31:0] i;
        h    = img_word(OFF_LFANEW);
        nsec = img_half(h + OFF_NSEC);
        opt  = img_half(h + OFF_OPT_SIZE);
        if (img_word(h + OFF_SEC_ALIGN) == img_word(h + OFF_FILE_ALGN))
            return rva;
        if (rva <= img_word(h + OFF_HDR_SIZE))
            return rva;
        if (nsec == 0)
            return rva;
        if (nsec > MAX_SECTIONS)
            nsec = MAX_SECTIONS;
        tab = h + OFF_SEC_TAB + opt;
        for (i = 0; i + 1 < nsec; i++)
        begin
            va      = img_word(tab + OFF_SEC_VA + i * SEC_ENTRY);
            va_next = img_word(tab + OFF_SEC_VA + (i + 1) * SEC_ENTRY);
            raw     = img_word(tab + OFF_SEC_RAW + i * SEC_ENTRY);
            if (rva >= va && rva < va_next)
                return rva - va + raw;
        end
        va  = img_word(tab + OFF_SEC_VA + (nsec - 1) * SEC_ENTRY);
        raw = img_word(tab + OFF_SEC_RAW + (nsec - 1) * SEC_ENTRY);
        return rva - va + raw;
    endfunction

    function automatic export_res_t resolve_export(op_t op, logic [31:0] key,
                                                   logic [15:0] ordv);
        export_res_t res;
        logic [31:0] dir;
        logic [31:0] funcs;
        logic [31:0] names;
        logic [31:0] ords;
        logic [31:0] count;
        logic [31:0] ord;
        logic [31:0] i;
        dir      = rva_to_file(img_word(img_word(OFF_LFANEW) + OFF_EXPORT));
        funcs    = rva_to_file(img_word(dir + OFF_FUNCS));
        res.rva  = 32'd0;
        res.hit  = 1'b1;
        if (op == OP_ORD)
        begin
            ord     = {16'd0, ordv} - img_word(dir + OFF_ORD_BASE);
            res.rva = img_word(funcs + ord * 4);
            return res;
        end
        count = img_word(dir + OFF_NUM_NAMES);
        names = rva_to_file(img_word(dir + OFF_NAMES));
        ords  = rva_to_file(img_word(dir + OFF_ORDS));
        if (count > MAX_NAMES)
            count = MAX_NAMES;
        for (i = 0; i < count; i++)
        begin
            if (img_word(names + i * 4) == key)
            begin
                ord     = img_half(ords + i * 2);
                res.rva = img_word(funcs + ord * 4);
                return res;
            end
        end
        res.hit = 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Item driving
    // ------------------------------------------------------------------------
    task automatic send_item(op_t op, logic [15:0] addr, logic [7:0] data,
                             logic [31:0] key, logic [15:0] ordv);
        int gap;
        gap = gap_len();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'd0, ordv, key, data, addr, op};
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        if (op == OP_LOAD)
        begin
            img[addr]     = data;
            written[addr] = 1'b1;
            n_loads++;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic load_byte(logic [31:0] a, logic [7:0] d);
        send_item(OP_LOAD, a[15:0], d, $urandom, 16'($urandom));
    endtask

    task automatic load_word(logic [31:0] a, logic [31:0] d, int nbytes);
        for (int k = 0; k < nbytes; k++)
            load_byte(a + k, d[8*k +: 8]);
    endtask

    // Fill any byte the lookup would touch before it was written, then send.
    task automatic lookup(op_t op, logic [31:0] key, logic [15:0] ordv);
        export_res_t res;
        forever
        begin
            first_gap = -1;
            res = resolve_export(op, key, ordv);
            if (first_gap < 0)
                break;
            load_byte(32'(first_gap), 8'($urandom_range(0, 3)));
        end
        pending_res.push_back(res);
        if (op == OP_ORD)
            n_ord++;
        else if (res.hit)
            n_name_hits++;
        else
            n_name_miss++;
        send_item(op, 16'($urandom), 8'($urandom), key, ordv);
    endtask

    task automatic build_image(int nsec, bit eq_align, bit big_hdr, int nnames,
                               int nwritten);
        logic [31:0] h;
        logic [31:0] opt;
        logic [31:0] tab;
        logic [31:0] dir_rva;
        logic [31:0] dir;
        logic [31:0] frva;
        logic [31:0] nrva;
        logic [31:0] orva;
        int          nwr;
        h   = $urandom_range(64, 200);
        opt = $urandom_range(0, 240);
        hdr_off = h;
        load_word(OFF_LFANEW, h, 4);
        load_word(h + OFF_NSEC, nsec, 2);
        load_word(h + OFF_OPT_SIZE, opt, 2);
        load_word(h + OFF_SEC_ALIGN, 32'h1000, 4);
        load_word(h + OFF_FILE_ALGN, eq_align ? 32'h1000 : 32'h200, 4);
        load_word(h + OFF_HDR_SIZE, big_hdr ? 32'hF000 : 32'h400, 4);
        tab = h + OFF_SEC_TAB + opt;
        for (int i = 0; i < nsec; i++)
        begin
            load_word(tab + OFF_SEC_VA + i * SEC_ENTRY, 32'h1000 * (i + 1), 4);
            load_word(tab + OFF_SEC_RAW + i * SEC_ENTRY, 32'h2000 + 32'h1000 * i, 4);
        end
        dir_rva    = 32'h1010 + $urandom_range(0, 255);
        func_count = nnames + 2;
        nwr        = (nwritten > nnames) ? nwritten : nnames;
        frva       = dir_rva + 32'h40;
        nrva       = frva + 4 * func_count;
        orva       = nrva + 4 * nwr;
        ord_base   = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom;
        load_word(h + OFF_EXPORT, dir_rva, 4);
        first_gap  = -1;
        dir = rva_to_file(dir_rva);
        dir_off = dir;
        load_word(dir + OFF_ORD_BASE, ord_base, 4);
        load_word(dir + OFF_NUM_NAMES, nnames, 4);
        load_word(dir + OFF_FUNCS, frva, 4);
        load_word(dir + OFF_NAMES, nrva, 4);
        load_word(dir + OFF_ORDS, orva, 4);
        first_gap = -1;
        frva = rva_to_file(frva);
        nrva = rva_to_file(nrva);
        orva = rva_to_file(orva);
        for (int i = 0; i < func_count; i++)
            load_word(frva + 4 * i, $urandom, 4);
        export_names.delete();
        for (int i = 0; i < nwr; i++)
        begin
            export_names.push_back($urandom);
            load_word(nrva + 4 * i, export_names[i], 4);
        end
        // large tables only get ordinals for the first few names
        for (int i = 0; i < ((nwr > 16) ? 16 : nwr); i++)
            load_word(orva + 2 * i, ($urandom_range(0, 9) == 0) ? $urandom
                      : $urandom_range(0, func_count - 1), 2);
    endtask

    function automatic logic [31:0] pick_name(int limit);
        if (export_names.size() == 0 || $urandom_range(0, 3) == 0)
            return $urandom;
        return export_names[$urandom_range(0, limit - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready = 1'b0;
        else if (stall > 0)
        begin
            m_axis_tready = 1'b0;
            stall--;
        end
        else
        begin
            m_axis_tready = 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall = gap_len();
        end
    end

    always @(posedge clk)
    begin
        export_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (pending_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                want = pending_res.pop_front();
                if (m_axis_tdata[31:0] !== want.rva || m_axis_tdata[32] !== want.hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected rva %h found %b, got rva %h found %b",
                                 want.rva, want.hit, m_axis_tdata[31:0], m_axis_tdata[32]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_equal_align();
        build_image(2, 1'b1, 1'b0, 4, 0);
        for (int i = 0; i < 4; i++)
            lookup(OP_NAME, export_names[i], 16'd0);
        lookup(OP_NAME, 32'hFFFF_FFFF, 16'd0);
        lookup(OP_ORD, 32'd0, ord_base[15:0]);
    endtask

    task automatic test_header_shortcut();
        build_image(3, 1'b0, 1'b1, 3, 0);
        lookup(OP_NAME, export_names[2], 16'd0);
        lookup(OP_ORD, 32'd0, ord_base[15:0] + 16'd1);
    endtask

    task automatic test_no_sections();
        build_image(0, 1'b0, 1'b0, 2, 0);
        lookup(OP_NAME, export_names[0], 16'd0);
        lookup(OP_NAME, 32'd0, 16'd0);
        lookup(OP_ORD, 32'd0, 16'hFFFF);
        // ordinal under the base wraps
        lookup(OP_ORD, 32'd0, 16'd0);
    endtask

    task automatic test_many_sections();
        build_image(3, 1'b0, 1'b0, 3, 0);
        // section count above the limit; the tables sit in the first section
        load_word(hdr_off + OFF_NSEC, MAX_SECTIONS + 4, 2);
        lookup(OP_NAME, export_names[1], 16'd0);
        lookup(OP_ORD, 32'd0, ord_base[15:0]);
    endtask

    task automatic test_many_names();
        build_image(1, 1'b0, 1'b0, 4, 0);
        // name count above the limit; only hits are looked up
        load_word(dir_off + OFF_NUM_NAMES, MAX_NAMES + 1000, 4);
        lookup(OP_NAME, export_names[3], 16'd0);
        lookup(OP_NAME, export_names[0], 16'd0);
        lookup(OP_ORD, 32'd0, ord_base[15:0] + 16'd2);
    endtask

    task automatic test_unused_op();
        send_item(OP_NONE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_NONE, 16'h0000, 8'h00, 32'h0, 16'h0);
    endtask

    task automatic test_random();
        int r;
        for (int img_n = 0; img_n < 2; img_n++)
        begin
            no_idle = (img_n == 1);
            build_image($urandom_range(0, 4), $urandom_range(0, 3) == 0,
                        $urandom_range(0, 7) == 0, $urandom_range(1, 6), 0);
            for (int n = 0; n < 25; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    lookup(OP_NAME, pick_name(export_names.size()), 16'd0);
                else if (r < 80)
                    lookup(OP_ORD, $urandom,
                           ($urandom_range(0, 4) == 0) ? 16'($urandom)
                           : 16'(ord_base[15:0] + $urandom_range(0, func_count - 1)));
                else if (r < 95)
                    load_byte($urandom_range(0, 65535), 8'($urandom));
                else
                    send_item(OP_NONE, 16'($urandom), 8'($urandom), $urandom,
                              16'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        n_loads       = 0;
        n_name_hits   = 0;
        n_name_miss   = 0;
        n_ord         = 0;
        n_results     = 0;
        stall         = 0;
        no_idle       = 1'b0;
        for (int i = 0; i < IMAGE_BYTES; i++)
        begin
            img[i]     = 8'd0;
            written[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_unused_op();
        test_equal_align();
        test_header_shortcut();
        test_no_sections();
        test_many_sections();
        test_many_names();
        test_random();

        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("loads %0d, name lookups %0d found / %0d not found, ordinal lookups %0d",
                 n_loads, n_name_hits, n_name_miss, n_ord);
        $display("results checked %0d, mismatches %0d", n_results, mismatches);
        if (mismatches == 0 && pending_res.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
